/* rtl/cpf_pkg.sv */
// Shared types, constants and the CRC byte update of the CRC-16 packet framer.
// Depends on nothing; every other file of the framer refers to it by scoped names.
`timescale 1ns / 1ps

package cpf_pkg;

  localparam int MAX_PAYLOAD_DEF = 255;
  localparam int PREFIX_MAX_DEF  = 8;

  localparam int PREFIX_BYTES_N  = 8;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 64;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_PREFIX_BYTES = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PREFIX_COUNT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CRC_SEED     = 2'd2;

  localparam logic [15:0] CRC_POLY       = 16'h8408;
  localparam logic [15:0] CRC_SEED_RESET = 16'hFFFF;
  localparam logic [3:0]  PREFIX_COUNT_RESET = 4'd1;
  localparam logic [7:0]  CHAR_CR        = 8'h0D;
  localparam logic [7:0]  CHAR_LF        = 8'h0A;

  typedef struct packed {
    logic [PREFIX_BYTES_N-1:0][7:0] prefix_bytes;
    logic [3:0]                     prefix_count;
    logic [15:0]                    crc_seed;
  } cfg_t;

  // One classified request: which parts of the frame it produces.
  typedef struct packed {
    logic        start;
    logic        pay;
    logic        stop;
    logic [15:0] mtype;
    logic [7:0]  mlen;
    logic [7:0]  pbyte;
  } job_t;

  // Reflected CCITT update, least significant bit first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* rtl/cpf_if.sv */
// Channel interfaces of the CRC-16 packet framer: input, result and configuration.
// Depends on cpf_pkg for the configuration port widths.
`timescale 1ns / 1ps

interface cpf_in_if;
  logic        valid;
  logic        ready;
  logic        frame_start;
  logic        frame_stop;
  logic [15:0] message_type;
  logic [7:0]  payload_length;
  logic        byte_present;
  logic [7:0]  payload_byte;

  modport source (output valid, frame_start, frame_stop, message_type, payload_length,
                  byte_present, payload_byte, input ready);
  modport sink   (input valid, frame_start, frame_stop, message_type, payload_length,
                  byte_present, payload_byte, output ready);
endinterface

interface cpf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       run_last;
  logic       frame_last;

  modport source (output valid, line_byte, run_last, frame_last, input ready);
  modport sink   (input valid, line_byte, run_last, frame_last, output ready);
endinterface

interface cpf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [cpf_pkg::CFG_INDEX_W-1:0]  index;
  logic [cpf_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/cpf_front.sv */
// Front end of the framer: accepts requests, tracks frame state and classifies each request.
// Depends on cpf_pkg and cpf_in_if; feeds cpf_queue.
`timescale 1ns / 1ps

module cpf_front #(
  parameter int MAX_PAYLOAD = cpf_pkg::MAX_PAYLOAD_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  cpf_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          q_push,
  output cpf_pkg::job_t q_job
);

  localparam int BT_W = $clog2(MAX_PAYLOAD + 1);

  logic            in_frame_r, in_frame_nxt;
  logic [BT_W-1:0] bytes_taken_r, bytes_taken_nxt;
  logic            accept;
  logic            open;
  logic            room;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    open = in_ch.frame_start || in_frame_r;
    // A start clears the count, so there is always room for its byte.
    room = in_ch.frame_start || (bytes_taken_r < BT_W'(MAX_PAYLOAD));

    q_job.start = in_ch.frame_start;
    q_job.pay   = open && in_ch.byte_present && room;
    q_job.stop  = open && in_ch.frame_stop;
    q_job.mtype = in_ch.message_type;
    q_job.mlen  = in_ch.payload_length;
    q_job.pbyte = in_ch.payload_byte;

    q_push = accept && (q_job.start || q_job.pay || q_job.stop);

    in_frame_nxt    = in_frame_r;
    bytes_taken_nxt = bytes_taken_r;
    if (accept) begin
      in_frame_nxt    = open && !in_ch.frame_stop;
      bytes_taken_nxt = (in_ch.frame_start ? '0 : bytes_taken_r) + BT_W'(q_job.pay);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r    <= 1'b0;
      bytes_taken_r <= '0;
    end else begin
      in_frame_r    <= in_frame_nxt;
      bytes_taken_r <= bytes_taken_nxt;
    end
  end

endmodule

/* rtl/cpf_queue.sv */
// Short request queue between the front end and the byte sequencer of the framer.
// Depends on cpf_pkg for the request type and depth.
`timescale 1ns / 1ps

module cpf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cpf_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output cpf_pkg::job_t head_job
);

  localparam int PTR_W = $clog2(cpf_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(cpf_pkg::QUEUE_DEPTH + 1);

  cpf_pkg::job_t mem_r [cpf_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full       = (cnt_r == CNT_W'(cpf_pkg::QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(cpf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(cpf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("request queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid) else $error("request queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(cpf_pkg::QUEUE_DEPTH)) else $error("request queue count out of range");
`endif

endmodule

/* rtl/cpf_back.sv */
// Byte sequencer of the framer: expands each queued request into prefix, header,
// payload and trailer bytes, keeps the running CRC and drives the output register.
// Depends on cpf_pkg and cpf_out_if.
`timescale 1ns / 1ps

module cpf_back #(
  parameter int PREFIX_MAX = cpf_pkg::PREFIX_MAX_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cpf_pkg::cfg_t cfg,
  input  logic          head_valid,
  input  cpf_pkg::job_t head_job,
  output logic          pop,
  cpf_out_if.source     out_ch
);

  localparam int SUB_MAX = (PREFIX_MAX > 4) ? PREFIX_MAX : 4;
  localparam int SUB_W   = $clog2(SUB_MAX);

  localparam logic [2:0] PH_BEGIN  = 3'd0;
  localparam logic [2:0] PH_PREFIX = 3'd1;
  localparam logic [2:0] PH_HDR    = 3'd2;
  localparam logic [2:0] PH_PAY    = 3'd3;
  localparam logic [2:0] PH_TRL    = 3'd4;

  logic [2:0]       phase_r, phase_nxt;
  logic [SUB_W-1:0] sub_r, sub_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_run_last_r, out_run_last_nxt;
  logic             out_frame_last_r, out_frame_last_nxt;

  logic [3:0]       pcnt;
  logic [2:0]       first_ph;
  logic [2:0]       ph;
  logic [SUB_W-1:0] s;
  logic [2:0]       pidx;
  logic             adv;
  logic             emit;
  logic             done;
  logic [7:0]       cur_byte;
  logic [2:0]       after_hdr;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.line_byte  = out_byte_r;
  assign out_ch.run_last   = out_run_last_r;
  assign out_ch.frame_last = out_frame_last_r;

  always_comb begin
    pcnt = (cfg.prefix_count > 4'(PREFIX_MAX)) ? 4'(PREFIX_MAX) : cfg.prefix_count;

    if (head_job.start) begin
      first_ph = (pcnt != 4'd0) ? PH_PREFIX : PH_HDR;
    end else if (head_job.pay) begin
      first_ph = PH_PAY;
    end else begin
      first_ph = PH_TRL;
    end
    ph   = (phase_r == PH_BEGIN) ? first_ph : phase_r;
    s    = (phase_r == PH_BEGIN) ? '0 : sub_r;
    pidx = 3'(s);

    adv  = !out_valid_r || out_ch.ready;
    emit = head_valid && adv;

    after_hdr = head_job.pay ? PH_PAY : (head_job.stop ? PH_TRL : PH_BEGIN);

    cur_byte  = 8'h00;
    crc_nxt   = crc_r;
    phase_nxt = phase_r;
    sub_nxt   = sub_r;
    done      = 1'b0;

    case (ph)
      PH_PREFIX: begin
        cur_byte = cfg.prefix_bytes[pidx];
        if (4'(s) + 4'd1 == pcnt) begin
          phase_nxt = PH_HDR;
          sub_nxt   = '0;
        end else begin
          phase_nxt = PH_PREFIX;
          sub_nxt   = s + SUB_W'(1);
        end
      end
      PH_HDR: begin
        case (s)
          SUB_W'(0): cur_byte = head_job.mtype[7:0];
          SUB_W'(1): cur_byte = head_job.mtype[15:8];
          SUB_W'(2): cur_byte = head_job.mlen;
          default:   cur_byte = 8'h00;
        endcase
        // The header restarts the CRC from the seed.
        crc_nxt = cpf_pkg::crc_byte((s == '0) ? cfg.crc_seed : crc_r, cur_byte);
        if (s == SUB_W'(3)) begin
          phase_nxt = after_hdr;
          sub_nxt   = '0;
          done      = (after_hdr == PH_BEGIN);
        end else begin
          phase_nxt = PH_HDR;
          sub_nxt   = s + SUB_W'(1);
        end
      end
      PH_PAY: begin
        cur_byte  = head_job.pbyte;
        crc_nxt   = cpf_pkg::crc_byte(crc_r, cur_byte);
        phase_nxt = head_job.stop ? PH_TRL : PH_BEGIN;
        sub_nxt   = '0;
        done      = !head_job.stop;
      end
      PH_TRL: begin
        case (s)
          SUB_W'(0): cur_byte = crc_r[7:0];
          SUB_W'(1): cur_byte = crc_r[15:8];
          SUB_W'(2): cur_byte = cpf_pkg::CHAR_CR;
          default:   cur_byte = cpf_pkg::CHAR_LF;
        endcase
        if (s == SUB_W'(3)) begin
          phase_nxt = PH_BEGIN;
          sub_nxt   = '0;
          done      = 1'b1;
        end else begin
          phase_nxt = PH_TRL;
          sub_nxt   = s + SUB_W'(1);
        end
      end
      default: begin
        cur_byte = 8'h00;
      end
    endcase

    if (!emit) begin
      crc_nxt   = crc_r;
      phase_nxt = phase_r;
      sub_nxt   = sub_r;
      done      = 1'b0;
    end
    pop = done;

    out_valid_nxt      = out_valid_r;
    out_byte_nxt       = out_byte_r;
    out_run_last_nxt   = out_run_last_r;
    out_frame_last_nxt = out_frame_last_r;
    if (adv) begin
      out_valid_nxt = emit;
      if (emit) begin
        out_byte_nxt       = cur_byte;
        out_run_last_nxt   = done;
        out_frame_last_nxt = (ph == PH_TRL) && (s == SUB_W'(3));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_BEGIN;
      sub_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      sub_r       <= sub_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r            <= crc_nxt;
    out_byte_r       <= out_byte_nxt;
    out_run_last_r   <= out_run_last_nxt;
    out_frame_last_r <= out_frame_last_nxt;
  end

`ifndef SYNTHESIS
  a_frame_last_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_frame_last_r |-> out_run_last_r && (out_byte_r == cpf_pkg::CHAR_LF))
    else $error("frame end not marked as last byte of its request");
  a_job_held_midway: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_BEGIN |-> head_valid)
    else $error("sequencer mid-request with an empty queue");
  a_pop_only_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> emit) else $error("request retired without emitting its last byte");
`endif

endmodule

/* rtl/crc16_packet_framer_unit.sv */
// Top level of the CRC-16 packet framer: configuration registers, front end,
// request queue and byte sequencer. Depends on cpf_pkg, cpf_if, cpf_front,
// cpf_queue and cpf_back.
`timescale 1ns / 1ps

// Usage
// The input channel in_ch takes one request per handshake. A request with
// frame_start opens a frame: the sequencer emits the prefix bytes, the message
// type and the length (each 16 bits, low byte first). A request with
// byte_present in an open frame forwards one payload byte (up to MAX_PAYLOAD),
// and frame_stop closes an open frame with the CRC (low byte first), carriage
// return and line feed. The result channel out_ch carries one byte per
// handshake; run_last marks the final byte of a request and frame_last the
// closing line feed. With the sequencer free, a request passes the queue write
// and then the output register before its first byte is on out_ch. The
// sequencer emits one byte per cycle while the receiver takes them, so a
// payload-only request yields one byte, and a request with a start yields the
// prefix bytes plus four header bytes, plus one for a byte and four for a stop.
// A two-entry queue lets the front end keep accepting while the sequencer works
// through a long request. When the receiver stalls, the output register holds
// its byte, the sequencer waits, and input ready falls once the queue is full.
// Reset (synchronous, active low) empties the queue, closes any open frame and
// restores the registers: zeroed prefix bytes, a prefix count of one, seed FFFF.
// Configuration writes on cfg_ch are always ready and belong in idle periods.

module crc16_packet_framer_unit #(
  parameter int MAX_PAYLOAD = cpf_pkg::MAX_PAYLOAD_DEF,
  parameter int PREFIX_MAX  = cpf_pkg::PREFIX_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cpf_in_if.sink     in_ch,
  cpf_out_if.source  out_ch,
  cpf_cfg_if.sink    cfg_ch
);

  cpf_pkg::cfg_t cfg_r;
  logic          q_push;
  cpf_pkg::job_t q_job;
  logic          q_full;
  logic          q_pop;
  logic          head_valid;
  cpf_pkg::job_t head_job;

  // Register file: always ready, writes to unused indexes are dropped.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prefix_bytes <= '0;
      cfg_r.prefix_count <= cpf_pkg::PREFIX_COUNT_RESET;
      cfg_r.crc_seed     <= cpf_pkg::CRC_SEED_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        cpf_pkg::CFG_PREFIX_BYTES: cfg_r.prefix_bytes <= cfg_ch.data;
        cpf_pkg::CFG_PREFIX_COUNT: cfg_r.prefix_count <= cfg_ch.data[3:0];
        cpf_pkg::CFG_CRC_SEED:     cfg_r.crc_seed     <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  // The front end decides which parts of the frame each request produces.
  cpf_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (q_job)
  );

  cpf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // The sequencer turns each queued request into bytes and keeps the CRC.
  cpf_back #(
    .PREFIX_MAX(PREFIX_MAX)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

endmodule
